// ===== hdl/ladrc_pkg.sv =====
// shared types, constants and saturation helpers for the first-order adrc block
// no dependencies; imported by every module of the block
`default_nettype none

package ladrc_pkg;

  // digit width of the serial multiplier, in bits per cycle (power of two, 1 to 8)
  localparam int MUL_DIGIT_W = 2;
  // quotient magnitude width: 32-bit numerator scaled up by 16 fraction bits
  localparam int QUO_W = 48;
  // configuration index width
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WC       = 3'd0,
    REG_W0       = 3'd1,
    REG_GAIN     = 3'd2,
    REG_TS       = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_SETPOINT = 3'd5
  } reg_index_t;

  // operation codes of an input item
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
    logic               gain_zero;
  } out_item_t;

  // divider result handed to the sequencer
  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } div_res_t;

  // sequencer steps: idle, then one per product, then the division and the output load
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_W0E,
    ST_M_BU,
    ST_M_TS_S,
    ST_M_W0W0,
    ST_M_W2E,
    ST_M_TS_W2E,
    ST_M_WC,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] sum;
    sum = 64'(a) + 64'(b);
    return sat32(sum);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] dif;
    dif = 64'(a) - 64'(b);
    return sat32(dif);
  endfunction

  // saturating doubling
  function automatic logic signed [31:0] sat_dbl(input logic signed [31:0] a);
    logic signed [63:0] d;
    d = {{31{a[31]}}, a, 1'b0};
    return sat32(d);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ladrc_mul.sv =====
// digit-serial signed q16.16 multiplier: shift-add over magnitudes, then sign fix,
// floor shift and saturation; depends on ladrc_pkg
`default_nettype none

module ladrc_mul #(
  parameter int DIGIT_W = ladrc_pkg::MUL_DIGIT_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [31:0]      result
);
  import ladrc_pkg::*;

  localparam int STEPS = 32 / DIGIT_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [31:0]            mcand;
  logic [63:0]            p;
  logic                   neg;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   fix;
  logic signed [63:0]     prod;
  logic [31+DIGIT_W:0]    mc_ext;
  logic [31+DIGIT_W:0]    dg_ext;
  logic [31+DIGIT_W:0]    sum;
  logic [31:0]            a_mag;
  logic [31:0]            b_mag;

  // operand magnitudes; the most negative value maps onto 2^31
  assign a_mag = a[31] ? 32'(-a) : 32'(a);
  assign b_mag = b[31] ? 32'(-b) : 32'(b);

  // one digit of the multiplier times the multiplicand, added to the upper half
  assign mc_ext = {{DIGIT_W{1'b0}}, mcand};
  assign dg_ext = {{32{1'b0}}, p[DIGIT_W-1:0]};
  assign sum    = {{DIGIT_W{1'b0}}, p[63:32]} + mc_ext * dg_ext;

  // control: load, digit steps, sign fix
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fix  <= 1'b0;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: partial product register and signed product
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a_mag;
      p     <= {32'd0, b_mag};
      neg   <= a[31] ^ b[31];
    end else if (busy) begin
      p <= {sum, p[31:DIGIT_W]};
    end else if (fix) begin
      prod <= neg ? $signed(~p + 64'd1) : $signed(p);
    end
  end

  // floor shift by the fraction width, then saturate
  assign result = sat32(prod >>> 16);

endmodule

`default_nettype wire

// ===== hdl/ladrc_div.sv =====
// bit-serial restoring divider for the drive: (num * 2^16) / den, truncated toward
// zero and clamped to the limit; depends on ladrc_pkg
`default_nettype none

module ladrc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  input  wire logic [30:0]        limit,
  output logic                    done,
  output ladrc_pkg::div_res_t     res
);
  import ladrc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [31:0]      dmag;
  logic [31:0]      rem;
  logic [QUO_W-1:0] quo;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fin;
  logic [32:0]      shifted;
  logic [32:0]      diff;
  logic             ge;
  logic [31:0]      num_mag;
  logic [31:0]      lim_ext;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign lim_ext = {1'b0, limit};

  // one quotient bit per cycle
  assign shifted = {rem, quo[QUO_W-1]};
  assign diff    = shifted - {1'b0, dmag};
  assign ge      = shifted >= {1'b0, dmag};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: remainder and quotient shift, then sign and clamp
  always_ff @(posedge clk) begin
    if (start) begin
      dmag <= den[31] ? 32'(-den) : 32'(den);
      rem  <= '0;
      quo  <= {num_mag, 16'd0};
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      quo <= {quo[QUO_W-2:0], ge};
    end else if (fin) begin
      if (quo > QUO_W'(lim_ext)) begin
        res.drive   <= neg ? $signed(-lim_ext) : $signed(lim_ext);
        res.clamped <= 1'b1;
      end else begin
        res.drive   <= neg ? $signed(-quo[31:0]) : $signed(quo[31:0]);
        res.clamped <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/linear_adrc_first_order.sv =====
// top level of the first-order linear adrc: configuration registers, sequencer,
// observer state and output register; depends on ladrc_pkg, ladrc_mul, ladrc_div
//
//   channel  | signals                          | item
//   ---------+----------------------------------+-------------------------------
//   input    | in_valid, in_stall, in_data      | operation, measurement
//   output   | out_valid, out_stall, out_data   | drive, clamped, gain_zero
//   config   | cfg_write, cfg_index, cfg_data   | one register write per cycle
//
// an update's seven products go one after another through the shared digit-serial
// multiplier, each with a launch, the digit steps, a sign fix and a done; then the drive
// goes through the 48-step bit-serial divider, skipped when the gain is zero, and a load
// into the output register; the next item is taken in the cycle after the load at the
// earliest, and a clear leaves the block idle, ready for the next item.
// in_stall is high from the cycle after an update is taken until its result sits in
// the output register, which holds it while out_stall is high.
// reset clears the configuration registers, the observer state and the last drive.
`default_nettype none

module linear_adrc_first_order #(
  parameter int DIGIT_W = ladrc_pkg::MUL_DIGIT_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ladrc_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ladrc_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_write,
  input  wire logic [ladrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                         cfg_data
);
  import ladrc_pkg::*;

  // configuration
  logic [30:0]        wc;
  logic [30:0]        w0;
  logic signed [31:0] gain;
  logic [30:0]        ts;
  logic [30:0]        limit;
  logic signed [31:0] setp;

  // sequencer
  seq_state_t state;
  seq_state_t state_next;
  logic       launch;
  logic       mul_start;
  logic       div_start;
  logic       out_load;

  // observer state and intermediates
  logic signed [31:0] z1;
  logic signed [31:0] z2;
  logic signed [31:0] u_prev;
  logic signed [31:0] e;
  logic signed [31:0] s;
  logic signed [31:0] t;
  logic signed [31:0] num;
  logic signed [31:0] drive_r;
  logic               clamped_r;
  logic               gz_r;

  // arithmetic units
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_done;
  logic signed [31:0] mul_res;
  logic               div_done;
  div_res_t           div_res;
  logic signed [31:0] lim_s;

  assign lim_s = $signed({1'b0, limit});

  ladrc_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  ladrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (gain),
    .limit (limit),
    .done  (div_done),
    .res   (div_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wc    <= '0;
      w0    <= '0;
      gain  <= '0;
      ts    <= '0;
      limit <= '0;
      setp  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WC:       wc    <= cfg_data[30:0];
        REG_W0:       w0    <= cfg_data[30:0];
        REG_GAIN:     gain  <= $signed(cfg_data);
        REG_TS:       ts    <= cfg_data[30:0];
        REG_LIMIT:    limit <= cfg_data[30:0];
        REG_SETPOINT: setp  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // multiplier operands for each step
  always_comb begin
    case (state)
      ST_M_W0E: begin
        mul_a = $signed({1'b0, w0});
        mul_b = e;
      end
      ST_M_BU: begin
        mul_a = gain;
        mul_b = u_prev;
      end
      ST_M_TS_S: begin
        mul_a = $signed({1'b0, ts});
        mul_b = s;
      end
      ST_M_W0W0: begin
        mul_a = $signed({1'b0, w0});
        mul_b = $signed({1'b0, w0});
      end
      ST_M_W2E: begin
        mul_a = t;
        mul_b = e;
      end
      ST_M_TS_W2E: begin
        mul_a = $signed({1'b0, ts});
        mul_b = t;
      end
      ST_M_WC: begin
        mul_a = $signed({1'b0, wc});
        mul_b = sat_sub(setp, z1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.operation == OP_UPDATE) begin
          state_next = ST_M_W0E;
        end
      end
      ST_M_W0E: begin
        mul_start = launch;
        if (mul_done) state_next = ST_M_BU;
      end
      ST_M_BU: begin
        mul_start = launch;
        if (mul_done) state_next = ST_M_TS_S;
      end
      ST_M_TS_S: begin
        mul_start = launch;
        if (mul_done) state_next = ST_M_W0W0;
      end
      ST_M_W0W0: begin
        mul_start = launch;
        if (mul_done) state_next = ST_M_W2E;
      end
      ST_M_W2E: begin
        mul_start = launch;
        if (mul_done) state_next = ST_M_TS_W2E;
      end
      ST_M_TS_W2E: begin
        mul_start = launch;
        if (mul_done) state_next = ST_M_WC;
      end
      ST_M_WC: begin
        mul_start = launch;
        if (mul_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        div_start = launch && (gain != 32'sd0);
        if (gain == 32'sd0 || div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // launch a unit on entry to each arithmetic step
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= (state_next != state) && (state_next != ST_OUT)
                && (state_next != ST_IDLE);
    end
  end

  // observer state and last drive
  always_ff @(posedge clk) begin
    if (rst) begin
      z1     <= '0;
      z2     <= '0;
      u_prev <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_data.operation == OP_CLEAR) begin
            z1     <= '0;
            z2     <= '0;
            u_prev <= '0;
          end
        end
        ST_M_TS_S: begin
          if (mul_done) z1 <= sat_add(z1, mul_res);
        end
        ST_M_TS_W2E: begin
          if (mul_done) z2 <= sat_add(z2, mul_res);
        end
        ST_OUT: begin
          if (out_load) u_prev <= drive_r;
        end
        default: ;
      endcase
    end
  end

  // intermediates of one update
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) e <= sat_sub(in_data.measurement, z1);
      end
      ST_M_W0E: begin
        if (mul_done) s <= sat_add(z2, sat_dbl(mul_res));
      end
      ST_M_BU: begin
        if (mul_done) s <= sat_add(s, mul_res);
      end
      ST_M_W0W0, ST_M_W2E: begin
        if (mul_done) t <= mul_res;
      end
      ST_M_WC: begin
        if (mul_done) num <= sat_sub(mul_res, z2);
      end
      ST_DIV: begin
        if (gain == 32'sd0) begin
          // no division: drive goes to the limit by the sign of the numerator, or to zero for a zero numerator
          if (num == 32'sd0) begin
            drive_r <= '0;
          end else if (num[31]) begin
            drive_r <= -lim_s;
          end else begin
            drive_r <= lim_s;
          end
          clamped_r <= (num != 32'sd0);
          gz_r      <= 1'b1;
        end else if (div_done) begin
          drive_r   <= div_res.drive;
          clamped_r <= div_res.clamped;
          gz_r      <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.drive     <= drive_r;
      out_data.clamped   <= clamped_r;
      out_data.gain_zero <= gz_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ladrc_checker.sv =====
// port-level checks of the first-order adrc block, bound to its top level
// depends on ladrc_pkg and linear_adrc_first_order
`default_nettype none

module ladrc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire ladrc_pkg::in_item_t             in_data,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire ladrc_pkg::out_item_t            out_data
);
  import ladrc_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // an update keeps the block busy on the next cycle
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.operation == OP_UPDATE |=> in_stall)
    else $error("update taken without going busy");

  // a clear item finishes at once
  a_clear_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.operation == OP_CLEAR |=> !in_stall)
    else $error("clear item left the block busy");

  // skipped division with no clamp means a zero numerator, so a zero drive
  a_gain_zero_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gain_zero && !out_data.clamped |-> out_data.drive == 32'sd0)
    else $error("zero gain result with nonzero unclamped drive");

endmodule

bind linear_adrc_first_order ladrc_checker u_ladrc_checker (.*);

`default_nettype wire
